// ===== hw/rtl/srt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int REC_W    = 2 * DATA_W;
  localparam int POS_W    = 6;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srt_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srt_cmp (
  input  wire logic signed [srt_pkg::DATA_W-1:0] a,
  input  wire logic signed [srt_pkg::DATA_W-1:0] b,
  output srt_pkg::cmp_res_t                      res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_record_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A bounded table of up to 16 records, each a signed key and a signed salary.
// A transaction is taken when start is high and busy is low; the operation is
// insert, delete by key, or sort by ascending salary and read out all records.
// Operation code 3 is taken and ignored. Every result appears on the out_ ports
// for exactly one cycle with out_valid high, and the receiver cannot stall it.
// Insert, and delete or display on an empty table, give one result in the cycle
// after the transaction is taken, and busy stays low.
// A delete scans the table record by record, reading each and comparing its key,
// then closes the gap by reading each later record and writing it one place
// lower, with the result in the cycle after the last compare or write.
// A display runs an insertion sort: each record is fetched in S_RDI and S_HOLD,
// then compared with the records below it, each larger one moving up a place,
// until it is placed. S_OUT0 then starts the read-out, and the n records appear
// on consecutive cycles, the final one marked by out_last.
// The pace of each step is set by the single read port of the record memory and
// the one shared comparator that serves both the key search and the salary sort.
// busy is high from the cycle after a multi-cycle transaction is taken until
// the cycle of its final result. Reset empties the table; memory contents are
// left as they are, and no unwritten entry is ever used.

module sorted_record_table (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           in_operation,
  input  wire logic signed [srt_pkg::DATA_W-1:0]    in_key,
  input  wire logic signed [srt_pkg::DATA_W-1:0]    in_pay,
  output logic                                      out_valid,
  output logic [1:0]                                out_status,
  output logic signed [srt_pkg::DATA_W-1:0]         out_key,
  output logic signed [srt_pkg::DATA_W-1:0]         out_pay,
  output logic [srt_pkg::POS_W-1:0]                 out_position,
  output logic                                      out_last
);

  localparam int CNT_W  = srt_pkg::CNT_W;
  localparam int ADDR_W = srt_pkg::ADDR_W;
  localparam int DATA_W = srt_pkg::DATA_W;
  localparam int REC_W  = srt_pkg::REC_W;
  localparam int POS_W  = srt_pkg::POS_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(srt_pkg::CAPACITY);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_D_RD  = 4'd1;
  localparam logic [3:0] S_D_CMP = 4'd2;
  localparam logic [3:0] S_SH_RD = 4'd3;
  localparam logic [3:0] S_SH_WR = 4'd4;
  localparam logic [3:0] S_RDI   = 4'd5;
  localparam logic [3:0] S_HOLD  = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_PLACE = 4'd8;
  localparam logic [3:0] S_OUT0  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  jdx_r, jdx_nxt;
  logic [DATA_W-1:0] opnd_r, opnd_nxt;
  logic [DATA_W-1:0] hold_key_r, hold_key_nxt;

  logic              valid_r, valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] pay_r, pay_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              last_r, last_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [REC_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  logic [DATA_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_pay;

  logic [DATA_W-1:0]  cmp_b;
  srt_pkg::cmp_res_t  cmp_res;

  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W-1:0]  jdx_dec;
  logic [CNT_W-1:0]  jdx_dec2;

  assign rd_key   = ram_rdata[REC_W-1:DATA_W];
  assign rd_pay   = ram_rdata[DATA_W-1:0];
  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec  = idx_r - CNT_W'(1);
  assign jdx_dec  = jdx_r - CNT_W'(1);
  assign jdx_dec2 = jdx_r - CNT_W'(2);
  assign cmp_b    = (state_r == S_D_CMP) ? rd_key : rd_pay;

  srt_ram #(
    .WIDTH(REC_W),
    .DEPTH(srt_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  srt_cmp u_cmp (
    .a  (opnd_r),
    .b  (cmp_b),
    .res(cmp_res)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    jdx_nxt      = jdx_r;
    opnd_nxt     = opnd_r;
    hold_key_nxt = hold_key_r;
    valid_nxt    = 1'b0;
    status_nxt   = srt_pkg::ST_OK;
    key_nxt      = '0;
    pay_nxt      = '0;
    pos_nxt      = '0;
    last_nxt     = 1'b1;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_operation)
            srt_pkg::OP_INSERT: begin
              valid_nxt = 1'b1;
              if (count_r == CAP_CNT) begin
                status_nxt = srt_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[ADDR_W-1:0];
                ram_wdata = {in_key, in_pay};
                count_nxt = count_r + CNT_W'(1);
              end
            end
            srt_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                valid_nxt  = 1'b1;
                status_nxt = srt_pkg::ST_EMPTY;
              end else begin
                opnd_nxt  = in_key;
                idx_nxt   = '0;
                state_nxt = S_D_RD;
              end
            end
            srt_pkg::OP_DISPLAY: begin
              if (count_r == '0) begin
                valid_nxt  = 1'b1;
                status_nxt = srt_pkg::ST_EMPTY;
              end else if (count_r == CNT_W'(1)) begin
                state_nxt = S_OUT0;
              end else begin
                idx_nxt   = CNT_W'(1);
                state_nxt = S_RDI;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_D_RD: begin
        ram_raddr = idx_r[ADDR_W-1:0];
        state_nxt = S_D_CMP;
      end

      S_D_CMP: begin
        if (cmp_res.eq) begin
          if (idx_inc == count_r) begin
            count_nxt = count_r - CNT_W'(1);
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (idx_inc == count_r) begin
          valid_nxt  = 1'b1;
          status_nxt = srt_pkg::ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_D_RD;
        end
      end

      S_SH_RD: begin
        ram_raddr = idx_inc[ADDR_W-1:0];
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        if (idx_r + CNT_W'(2) == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SH_RD;
        end
      end

      S_RDI: begin
        ram_raddr = idx_r[ADDR_W-1:0];
        state_nxt = S_HOLD;
      end

      S_HOLD: begin
        opnd_nxt     = rd_pay;
        hold_key_nxt = rd_key;
        jdx_nxt      = idx_r;
        ram_raddr    = idx_dec[ADDR_W-1:0];
        state_nxt    = S_CMP;
      end

      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_r[ADDR_W-1:0];
        if (cmp_res.lt) begin
          ram_wdata = ram_rdata;
          jdx_nxt   = jdx_dec;
          if (jdx_r == CNT_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr = jdx_dec2[ADDR_W-1:0];
          end
        end else begin
          ram_wdata = {hold_key_r, opnd_r};
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == count_r) ? S_OUT0 : S_RDI;
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_r[ADDR_W-1:0];
        ram_wdata = {hold_key_r, opnd_r};
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc == count_r) ? S_OUT0 : S_RDI;
      end

      S_OUT0: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        valid_nxt = 1'b1;
        key_nxt   = rd_key;
        pay_nxt   = rd_pay;
        pos_nxt   = POS_W'(idx_r);
        last_nxt  = (idx_inc == count_r);
        ram_raddr = idx_inc[ADDR_W-1:0];
        idx_nxt   = idx_inc;
        if (idx_inc == count_r) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    jdx_r      <= jdx_nxt;
    opnd_r     <= opnd_nxt;
    hold_key_r <= hold_key_nxt;
    status_r   <= status_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    pos_r      <= pos_nxt;
    last_r     <= last_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = valid_r;
  assign out_status   = status_r;
  assign out_key      = key_r;
  assign out_pay      = pay_r;
  assign out_position = pos_r;
  assign out_last     = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_record_table_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sorted_record_table_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic [1:0]                        in_operation,
  input wire logic                              out_valid,
  input wire logic [1:0]                        out_status,
  input wire logic [srt_pkg::POS_W-1:0]         out_position,
  input wire logic                              out_last
);

  // An insert transaction always completes in the following cycle.
  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == srt_pkg::OP_INSERT |=> out_valid && out_last)
    else $error("insert transaction did not return a result in the next cycle");

  // A read-out stream has no gaps.
  a_stream_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("read-out stream broken before its final record");

  // Positions within a read-out stream step by one.
  a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_position == $past(out_position) + 1'b1)
    else $error("read-out position did not advance by one");

  // Any status other than success ends the transaction.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != srt_pkg::ST_OK |-> out_last)
    else $error("error status reported without the last marker");

endmodule

bind sorted_record_table sorted_record_table_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_operation(in_operation),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_position(out_position),
  .out_last    (out_last)
);

`default_nettype wire

// ===== tb/srt_table_checker.sv =====
`timescale 1ns / 1ps

module srt_table_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [1:0]                           in_operation,
  input  logic signed [srt_pkg::DATA_W-1:0]    in_key,
  input  logic signed [srt_pkg::DATA_W-1:0]    in_pay,
  input  logic                                 out_valid,
  input  logic [1:0]                           out_status,
  input  logic signed [srt_pkg::DATA_W-1:0]    out_key,
  input  logic signed [srt_pkg::DATA_W-1:0]    out_pay,
  input  logic [srt_pkg::POS_W-1:0]            out_position,
  input  logic                                 out_last,
  output int                                   mismatch_count,
  output int                                   awaited_count,
  output int                                   items_taken,
  output int                                   replies_seen,
  output int                                   full_sorts,
  output int                                   refused_inserts
);

  typedef struct {
    logic [1:0]                        status;
    logic signed [srt_pkg::DATA_W-1:0] rec_key;
    logic signed [srt_pkg::DATA_W-1:0] rec_pay;
    logic [srt_pkg::POS_W-1:0]         rank;
    logic                              fin;
  } reply_t;

  reply_t                            awaited_replies[$];
  logic signed [srt_pkg::DATA_W-1:0] stored_key[srt_pkg::CAPACITY];
  logic signed [srt_pkg::DATA_W-1:0] stored_pay[srt_pkg::CAPACITY];
  int                                stored_count = 0;
  int                                bad_total = 0;
  int                                taken_total = 0;
  int                                seen_total = 0;
  int                                full_sort_total = 0;
  int                                refused_total = 0;

  task automatic queue_reply(input logic [1:0] status, input logic signed [31:0] k,
                             input logic signed [31:0] p, input int rank, input logic fin);
    reply_t r;
    r.status  = status;
    r.rec_key = k;
    r.rec_pay = p;
    r.rank    = rank[srt_pkg::POS_W-1:0];
    r.fin     = fin;
    awaited_replies.push_back(r);
  endtask

  task automatic sort_by_pay();
    logic signed [31:0] hold_key;
    logic signed [31:0] hold_pay;
    int j;
    for (int i = 1; i < stored_count; i++) begin
      hold_key = stored_key[i];
      hold_pay = stored_pay[i];
      j = i;
      while (j > 0 && hold_pay < stored_pay[j-1]) begin
        stored_key[j] = stored_key[j-1];
        stored_pay[j] = stored_pay[j-1];
        j--;
      end
      stored_key[j] = hold_key;
      stored_pay[j] = hold_pay;
    end
  endtask

  task automatic table_apply(input logic [1:0] op, input logic signed [31:0] k,
                             input logic signed [31:0] p);
    int hit;
    hit = -1;
    case (op)
      srt_pkg::OP_INSERT: begin
        if (stored_count >= srt_pkg::CAPACITY) begin
          refused_total++;
          queue_reply(srt_pkg::ST_FULL, 0, 0, 0, 1'b1);
        end else begin
          stored_key[stored_count] = k;
          stored_pay[stored_count] = p;
          stored_count++;
          queue_reply(srt_pkg::ST_OK, 0, 0, 0, 1'b1);
        end
      end
      srt_pkg::OP_DELETE: begin
        if (stored_count == 0) begin
          queue_reply(srt_pkg::ST_EMPTY, 0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < stored_count; i++) begin
            if (hit < 0 && stored_key[i] == k) hit = i;
          end
          if (hit < 0) begin
            queue_reply(srt_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1);
          end else begin
            for (int i = hit; i + 1 < stored_count; i++) begin
              stored_key[i] = stored_key[i+1];
              stored_pay[i] = stored_pay[i+1];
            end
            stored_count--;
            queue_reply(srt_pkg::ST_OK, 0, 0, 0, 1'b1);
          end
        end
      end
      srt_pkg::OP_DISPLAY: begin
        if (stored_count == 0) begin
          queue_reply(srt_pkg::ST_EMPTY, 0, 0, 0, 1'b1);
        end else begin
          if (stored_count == srt_pkg::CAPACITY) full_sort_total++;
          sort_by_pay();
          for (int i = 0; i < stored_count; i++) begin
            queue_reply(srt_pkg::ST_OK, stored_key[i], stored_pay[i], i,
                        i == stored_count - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input reply_t want, input reply_t got);
    bad_total++;
    if (bad_total <= 10) begin
      $display("%0t: %s: expected status %0d key %0d pay %0d position %0d last %0b",
               $time, what, want.status, want.rec_key, want.rec_pay, want.rank, want.fin);
      $display("%0t: %s:      got status %0d key %0d pay %0d position %0d last %0b",
               $time, what, got.status, got.rec_key, got.rec_pay, got.rank, got.fin);
    end
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n) begin
      if (out_valid !== 1'b0) begin
        seen_total++;
        got.status  = out_status;
        got.rec_key = out_key;
        got.rec_pay = out_pay;
        got.rank    = out_position;
        got.fin     = out_last;
        if (awaited_replies.size() == 0) begin
          want = '{default: '0};
          note_mismatch("unexpected result", want, got);
        end else begin
          want = awaited_replies.pop_front();
          if (out_valid !== 1'b1 || got.status !== want.status ||
              got.rec_key !== want.rec_key || got.rec_pay !== want.rec_pay ||
              got.rank !== want.rank || got.fin !== want.fin) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      if (start && !busy) begin
        taken_total++;
        table_apply(in_operation, in_key, in_pay);
      end
    end
    mismatch_count  <= bad_total;
    awaited_count   <= awaited_replies.size();
    items_taken     <= taken_total;
    replies_seen    <= seen_total;
    full_sorts      <= full_sort_total;
    refused_inserts <= refused_total;
  end

endmodule

// ===== tb/tb_sorted_record_table.sv =====
`timescale 1ns / 1ps

module tb_sorted_record_table;

  localparam int         RANDOM_ITEMS = 260;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 200;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [1:0]                        in_operation;
  logic signed [srt_pkg::DATA_W-1:0] in_key;
  logic signed [srt_pkg::DATA_W-1:0] in_pay;
  logic                              out_valid;
  logic [1:0]                        out_status;
  logic signed [srt_pkg::DATA_W-1:0] out_key;
  logic signed [srt_pkg::DATA_W-1:0] out_pay;
  logic [srt_pkg::POS_W-1:0]         out_position;
  logic                              out_last;

  int mismatch_count;
  int awaited_count;
  int items_taken;
  int replies_seen;
  int full_sorts;
  int refused_inserts;

  sorted_record_table u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_pay       (in_pay),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_key      (out_key),
    .out_pay      (out_pay),
    .out_position (out_position),
    .out_last     (out_last)
  );

  srt_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_pay          (in_pay),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_pay         (out_pay),
    .out_position    (out_position),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .awaited_count   (awaited_count),
    .items_taken     (items_taken),
    .replies_seen    (replies_seen),
    .full_sorts      (full_sorts),
    .refused_inserts (refused_inserts)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_run = 0;
      else idle_run++;
    end
    $display("No transaction for %0d cycles; giving up.", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic issue(input logic [1:0] op, input logic signed [31:0] k,
                       input logic signed [31:0] p);
    in_operation <= op;
    in_key       <= k;
    in_pay       <= p;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $signed($urandom_range(0, 7)) - 3;
    if (r < 80) return 32'sh7fff_ffff;
    if (r < 85) return 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_pay();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $signed($urandom_range(0, 4)) - 2;
    if (r < 45) return 32'sh7fff_ffff;
    if (r < 50) return 32'sh8000_0000;
    return $urandom;
  endfunction

  initial begin : stimulus
    int  done;
    int  r;
    bit  filling;
    bit  burst;
    logic [1:0] op;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = srt_pkg::OP_INSERT;
    in_key       = '0;
    in_pay       = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue(srt_pkg::OP_DISPLAY, 0, 0);
    issue(srt_pkg::OP_DELETE, 7, 0);
    issue(OP_UNUSED, -1, -1);
    pause(pick_gap(0));
    issue(srt_pkg::OP_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
    issue(srt_pkg::OP_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
    issue(srt_pkg::OP_INSERT, 5, 100);
    issue(srt_pkg::OP_INSERT, 9, 100);
    issue(srt_pkg::OP_INSERT, 5, -1);
    pause(pick_gap(0));
    issue(srt_pkg::OP_DELETE, 42, 0);
    issue(srt_pkg::OP_DELETE, 5, 0);
    issue(srt_pkg::OP_DISPLAY, 0, 0);
    for (int i = 0; i < 13; i++) begin
      issue(srt_pkg::OP_INSERT, 100 + i, 40 - 3 * (i % 5));
      pause(pick_gap(0));
    end
    issue(srt_pkg::OP_DISPLAY, 0, 0);

    done = 0;
    while (done < RANDOM_ITEMS) begin
      filling = ((done / 40) % 2) == 0;
      burst   = ((done / 20) % 4) == 1;
      r = $urandom_range(99);
      if (r < (filling ? 60 : 20))      op = srt_pkg::OP_INSERT;
      else if (r < (filling ? 80 : 75)) op = srt_pkg::OP_DELETE;
      else if (r < 96)                  op = srt_pkg::OP_DISPLAY;
      else                              op = OP_UNUSED;
      issue(op, pick_key(), pick_pay());
      if (op != OP_UNUSED) done++;
      pause(pick_gap(burst));
    end
    start <= 1'b0;

    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions through insert, delete and sorted read-out,",
             items_taken);
    $display("checking %0d results, with %0d full-table sorts and %0d refused inserts.",
             replies_seen, full_sorts, refused_inserts);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", mismatch_count, awaited_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/srt_pkg.sv
hw/rtl/srt_ram.sv
hw/rtl/srt_cmp.sv
hw/rtl/sorted_record_table.sv
hw/rtl/sorted_record_table_chk.sv
tb/srt_table_checker.sv
tb/tb_sorted_record_table.sv
